### src/c8exu_pkg.sv
// Shared constants and types for the CHIP-8 execute unit.
package c8exu_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam logic [11:0] FontBaseRst  = 12'd80;
  localparam logic [11:0] PcRst        = 12'd512;

  // Result status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StUnsup     = 2'd1;
  localparam logic [1:0] StOverflow  = 2'd2;
  localparam logic [1:0] StUnderflow = 2'd3;

  // Timer select codes
  localparam logic [1:0] TmNone  = 2'd0;
  localparam logic [1:0] TmDelay = 2'd1;
  localparam logic [1:0] TmSound = 2'd2;

  // One result item
  typedef struct packed {
    logic       last;
    logic [1:0] status;
    logic [7:0] timer_value;
    logic [1:0] timer_select;
    logic [7:0] write_data;
    logic [15:0] write_addr;
    logic       write_valid;
    logic [15:0] index_value;
    logic [11:0] next_pc;
  } c8exu_res_t;

endpackage

### src/chip8_register_execute_unit_top.sv
// CHIP-8 execute unit: register file, stack and a shared 8-bit ALU sequencer.
//
// Usage:
//  - s_axis carries one request: tdata = {delay_value, rnd_value, opcode},
//    opcode in bits 15:0. The unit is busy until all results of it are taken.
//  - m_axis gives one or more results; tlast marks the final one.
//  - cfg_we_i / cfg_wdata_i load font_base (address of the digit-0 sprite).
// Sequencing:
//  - A plain instruction runs S_EXEC, where decode, register read, one ALU
//    pass and write-back happen in the same cycle; its result is registered.
//    8xy4..8xy7 and 8xyE pass through S_FLAG to write VF.
//  - Fx33 runs the shared subtractor as a digit divider (S_BCD), then gives
//    three writes on back-to-back cycles while the receiver does not stall;
//    Fx55 gives x+1 writes, each fetched in S_STORE, then presented in S_OUT.
//  - The next request is taken in the cycle after the last result is taken,
//    so a new request is never taken before the last one is done.
// Reset puts V0..VF and I to zero, PC to 512, the stack empty, font_base 80.
// When the receiver stalls, the held result stays on m_axis and the unit waits.
module chip8_register_execute_unit_top
  import c8exu_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[15:0], rnd_value[23:16], delay_value[31:24]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[11:0], index_value[27:12], write_valid[28], write_addr[44:29],
  // write_data[52:45], timer_select[54:53], timer_value[62:55], status[64:63]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int unsigned SpW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LvW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FLAG, S_BCD, S_STORE, S_OUT
  } state_e;

  state_e      state_q;
  logic [15:0] op_q;
  logic [7:0]  rnd_q, dly_q;
  logic [11:0] font_q;
  logic [7:0]  vregs_q [16];
  logic [15:0] idx_q;
  logic [11:0] pc_q;
  logic [11:0] stack_q [STACK_DEPTH];
  logic [LvW-1:0] lvl_q;
  logic        flag_q;
  logic [7:0]  rem_q;
  logic [3:0]  hund_q, tens_q;
  logic [1:0]  bcd_q;
  logic [3:0]  cnt_q;
  c8exu_res_t  res_q;

  logic [3:0] x, y, n;
  logic [7:0] kk, vx, vy;
  logic [11:0] nnn, npc;
  assign x   = op_q[11:8];
  assign y   = op_q[7:4];
  assign n   = op_q[3:0];
  assign kk  = op_q[7:0];
  assign nnn = op_q[11:0];
  assign vx  = vregs_q[x];
  assign vy  = vregs_q[y];
  assign npc = pc_q + 12'd2;

  // Shared ALU: one 9-bit adder with operand selection
  logic [7:0] alu_a, alu_b;
  logic       alu_sub;
  logic [8:0] alu_sum;
  always_comb begin
    alu_a = vx;
    alu_b = vy;
    alu_sub = 1'b0;
    if (state_q == S_BCD) begin
      alu_a = rem_q;
      alu_b = (bcd_q == 2'd0) ? 8'd100 : 8'd10;
      alu_sub = 1'b1;
    end else begin
      case (op_q[15:12])
        4'h7: alu_b = kk;
        4'h8: begin
          if (n == 4'h5) alu_sub = 1'b1;
          if (n == 4'h7) begin
            alu_a = vy;
            alu_b = vx;
            alu_sub = 1'b1;
          end
        end
        default: ;
      endcase
    end
    alu_sum = alu_sub ? ({1'b0, alu_a} + {1'b0, ~alu_b} + 9'd1)
                      : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tdata  = {7'd0, res_q.status, res_q.timer_value, res_q.timer_select,
                          res_q.write_data, res_q.write_addr, res_q.write_valid,
                          res_q.index_value, res_q.next_pc};

  function automatic c8exu_res_t mk_res(input logic [11:0] pc, input logic [15:0] idx,
                                        input logic [1:0] st);
    c8exu_res_t r;
    r = '0;
    r.next_pc = pc;
    r.index_value = idx;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Call stack storage
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && op_q[15:12] == 4'h2 && lvl_q < LvW'(STACK_DEPTH)) begin
      stack_q[lvl_q[SpW-1:0]] <= npc;
    end
  end

  // Sequencer, register file and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      font_q  <= FontBaseRst;
      pc_q    <= PcRst;
      idx_q   <= '0;
      lvl_q   <= '0;
      for (int i = 0; i < 16; i++) vregs_q[i] <= '0;
    end else begin
      if (cfg_we_i) font_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q  <= s_axis_tdata[15:0];
            rnd_q <= s_axis_tdata[23:16];
            dly_q <= s_axis_tdata[31:24];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          c8exu_res_t res_n;
          state_e     state_n;
          res_n = mk_res(pc_q, idx_q, StUnsup);
          state_n = S_OUT;
          case (op_q[15:12])
            4'h0: begin
              if (op_q != 16'h00EE) res_n = mk_res(pc_q, idx_q, StUnsup);
              else if (lvl_q == '0) res_n = mk_res(pc_q, idx_q, StUnderflow);
              else begin
                lvl_q <= lvl_q - 1'b1;
                pc_q  <= stack_q[SpW'(lvl_q - 1'b1)];
                res_n = mk_res(stack_q[SpW'(lvl_q - 1'b1)], idx_q, StOk);
              end
            end
            4'h1: begin
              pc_q <= nnn;
              res_n = mk_res(nnn, idx_q, StOk);
            end
            4'h2: begin
              if (lvl_q >= LvW'(STACK_DEPTH)) res_n = mk_res(pc_q, idx_q, StOverflow);
              else begin
                lvl_q <= lvl_q + 1'b1;
                pc_q  <= nnn;
                res_n = mk_res(nnn, idx_q, StOk);
              end
            end
            4'h3, 4'h4, 4'h5, 4'h9: begin
              if ((op_q[15:12] == 4'h5 || op_q[15:12] == 4'h9) && n != 4'h0) begin
                res_n = mk_res(pc_q, idx_q, StUnsup);
              end else begin
                logic eq;
                eq = (op_q[15:12] == 4'h3 || op_q[15:12] == 4'h4) ? (vx == kk) : (vx == vy);
                if (eq ^ (op_q[15:12] == 4'h4 || op_q[15:12] == 4'h9)) begin
                  pc_q <= npc + 12'd2;
                  res_n = mk_res(npc + 12'd2, idx_q, StOk);
                end else begin
                  pc_q <= npc;
                  res_n = mk_res(npc, idx_q, StOk);
                end
              end
            end
            4'h6, 4'h7, 4'hC: begin
              vregs_q[x] <= (op_q[15:12] == 4'h6) ? kk :
                            (op_q[15:12] == 4'h7) ? alu_sum[7:0] : (rnd_q & kk);
              pc_q <= npc;
              res_n = mk_res(npc, idx_q, StOk);
            end
            4'h8: begin
              if (n inside {[4'h0:4'h7], 4'hE}) begin
                pc_q <= npc;
                res_n = mk_res(npc, idx_q, StOk);
                case (n)
                  4'h0: vregs_q[x] <= vy;
                  4'h1: vregs_q[x] <= vx | vy;
                  4'h2: vregs_q[x] <= vx & vy;
                  4'h3: vregs_q[x] <= vx ^ vy;
                  4'h4: begin
                    vregs_q[x] <= alu_sum[7:0];
                    flag_q <= alu_sum[8];
                  end
                  4'h5, 4'h7: begin
                    vregs_q[x] <= alu_sum[7:0];
                    flag_q <= alu_sum[8] && (alu_sum[7:0] != 8'd0);
                  end
                  4'h6: begin
                    vregs_q[x] <= {1'b0, vx[7:1]};
                    flag_q <= vx[0];
                  end
                  default: begin
                    vregs_q[x] <= {vx[6:0], 1'b0};
                    flag_q <= vx[7];
                  end
                endcase
                if (n inside {[4'h4:4'h7], 4'hE}) state_n = S_FLAG;
              end
            end
            4'hA: begin
              idx_q <= {4'd0, nnn};
              pc_q <= npc;
              res_n = mk_res(npc, {4'd0, nnn}, StOk);
            end
            4'hB: begin
              pc_q <= nnn + {4'd0, vregs_q[0]};
              res_n = mk_res(nnn + {4'd0, vregs_q[0]}, idx_q, StOk);
            end
            4'hF: begin
              case (kk)
                8'h07: begin
                  vregs_q[x] <= dly_q;
                  pc_q <= npc;
                  res_n = mk_res(npc, idx_q, StOk);
                end
                8'h15, 8'h18: begin
                  c8exu_res_t r;
                  r = mk_res(npc, idx_q, StOk);
                  r.timer_select = (kk == 8'h15) ? TmDelay : TmSound;
                  r.timer_value = vx;
                  pc_q <= npc;
                  res_n = r;
                end
                8'h1E: begin
                  idx_q <= idx_q + {8'd0, vx};
                  pc_q <= npc;
                  res_n = mk_res(npc, idx_q + {8'd0, vx}, StOk);
                end
                8'h29: begin
                  logic [15:0] a;
                  a = {4'd0, font_q} + {12'd0, vx[3:0]} + {10'd0, vx[3:0], 2'd0};
                  idx_q <= a;
                  pc_q <= npc;
                  res_n = mk_res(npc, a, StOk);
                end
                8'h33: begin
                  pc_q <= npc;
                  rem_q <= vx;
                  hund_q <= '0;
                  tens_q <= '0;
                  bcd_q <= 2'd0;
                  state_n = S_BCD;
                end
                8'h55: begin
                  pc_q <= npc;
                  cnt_q <= '0;
                  state_n = S_STORE;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
          res_q <= res_n;
          state_q <= state_n;
        end
        S_FLAG: begin
          vregs_q[15] <= {7'd0, flag_q};
          state_q <= S_OUT;
        end
        S_BCD: begin
          // Repeated subtraction: hundreds, then tens, then emit digits
          if (bcd_q == 2'd2) begin
            c8exu_res_t r;
            r = mk_res(pc_q, idx_q, StOk);
            r.write_valid = 1'b1;
            r.last = 1'b0;
            r.write_addr = idx_q;
            r.write_data = {4'd0, hund_q};
            res_q <= r;
            cnt_q <= '0;
            state_q <= S_OUT;
          end else if (!alu_sum[8]) begin
            bcd_q <= bcd_q + 2'd1;
          end else begin
            rem_q <= alu_sum[7:0];
            if (bcd_q == 2'd0) hund_q <= hund_q + 4'd1;
            else tens_q <= tens_q + 4'd1;
          end
        end
        S_STORE: begin
          c8exu_res_t r;
          r = mk_res(pc_q, idx_q, StOk);
          r.write_valid = 1'b1;
          r.write_addr = idx_q + {12'd0, cnt_q};
          r.write_data = vregs_q[cnt_q];
          r.last = (cnt_q == x);
          res_q <= r;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            if (res_q.last) state_q <= S_IDLE;
            else if (op_q[7:0] == 8'h55) begin
              cnt_q <= cnt_q + 4'd1;
              state_q <= S_STORE;
            end else begin
              // Next BCD digit
              cnt_q <= cnt_q + 4'd1;
              res_q.write_addr <= idx_q + {12'd0, cnt_q + 4'd1};
              res_q.write_data <= (cnt_q == 4'd0) ? {4'd0, tens_q} : rem_q;
              res_q.last <= (cnt_q == 4'd1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### src/c8exu_checker.sv
// Port-level checker for the CHIP-8 execute unit, bound to the top level.
module c8exu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Never ready for a request while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result valid");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // A failing status always ends the instruction and carries no write
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[64:63] != 2'd0 |-> m_axis_tlast && !m_axis_tdata[28])
    else $error("bad failing result");

  // Accepted request drops ready next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");

endmodule

bind chip8_register_execute_unit_top c8exu_checker u_c8exu_checker (.*);
